[src/tpa_pkg.sv]
// Shared types, constants and the phase-delay table builder for the triac phase-angle controller.
package tpa_pkg;

    // Mains timing and level resolution
    localparam int HALF_PERIOD_US = 10000;
    localparam int LEVEL_STEPS    = 100;
    localparam int LEVEL_W        = $clog2(LEVEL_STEPS + 1);

    // Field widths
    localparam int REQ_W   = 3;
    localparam int TEMP_W  = 12;
    localparam int LVL_W   = 7;
    localparam int TIME_W  = 16;
    localparam int PHASE_W = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Stream packing
    localparam int S_TDATA_W = 16;
    localparam int S_TUSER_W = 4;
    localparam int M_TDATA_W = 24;

    localparam logic [TIME_W-1:0] NO_FIRE   = 16'hFFFF;
    localparam logic [TIME_W-1:0] TIME_MAX  = 16'hFFFF;
    localparam logic [TIME_W-1:0] DELAY_MAX = TIME_W'(HALF_PERIOD_US - 1);
    localparam logic [LVL_W-1:0]  LEVEL_TOP = LVL_W'(LEVEL_STEPS);

    // Register reset values
    localparam logic [LVL_W-1:0]  RST_OUTPUT_LEVEL   = 7'd0;
    localparam logic [TIME_W-1:0] RST_DEBOUNCE       = 16'd3000;
    localparam logic [TIME_W-1:0] RST_PULSE_WIDTH    = 16'd100;
    localparam logic [TIME_W-1:0] RST_MIN_FIRE_DELAY = 16'd100;
    localparam logic [TEMP_W-1:0] RST_OVERHEAT_LIMIT = 12'd3000;
    localparam logic [TEMP_W-1:0] RST_FAN_ON_LIMIT   = 12'd2500;
    localparam logic [TEMP_W-1:0] RST_FAN_OFF_LIMIT  = 12'd2200;

    // Request kinds
    typedef enum logic [REQ_W-1:0] {
        REQ_TICK    = 3'd0,
        REQ_EDGE    = 3'd1,
        REQ_SAMPLE  = 3'd2,
        REQ_ENABLE  = 3'd3,
        REQ_DISABLE = 3'd4
    } req_t;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OUTPUT_LEVEL   = 3'd0,
        CFG_DEBOUNCE       = 3'd1,
        CFG_PULSE_WIDTH    = 3'd2,
        CFG_MIN_FIRE_DELAY = 3'd3,
        CFG_OVERHEAT_LIMIT = 3'd4,
        CFG_FAN_ON_LIMIT   = 3'd5,
        CFG_FAN_OFF_LIMIT  = 3'd6
    } cfg_idx_t;

    // Firing timer phase
    typedef enum logic [PHASE_W-1:0] {
        PH_IDLE  = 2'd0,
        PH_DELAY = 2'd1,
        PH_PULSE = 2'd2
    } phase_t;

    // Configuration register bank
    typedef struct packed {
        logic [LVL_W-1:0]  output_level;
        logic [TIME_W-1:0] debounce_window;
        logic [TIME_W-1:0] pulse_width;
        logic [TIME_W-1:0] min_fire_delay;
        logic [TEMP_W-1:0] overheat_limit;
        logic [TEMP_W-1:0] fan_on_limit;
        logic [TEMP_W-1:0] fan_off_limit;
    } cfg_t;

    // Delay lookup result
    typedef struct packed {
        logic              fire_ok;
        logic [TIME_W-1:0] delay;
    } delay_info_t;

    // Fixed-point constants for the table builder (Q28)
    localparam int          FX_SHIFT  = 28;
    localparam logic [63:0] FX_ONE    = 64'd1 << FX_SHIFT;
    localparam logic [63:0] FX_HALF   = FX_ONE >> 1;
    localparam logic [63:0] FX_QUART  = FX_ONE >> 2;
    localparam logic [63:0] FX_TWO_PI = 64'd1686629713;
    localparam logic [63:0] FX_U_DEN  = 64'(2 * HALF_PERIOD_US);
    localparam logic [63:0] TAYLOR_DIV_7 = 64'd210;
    localparam logic [63:0] TAYLOR_DIV_6 = 64'd156;
    localparam logic [63:0] TAYLOR_DIV_5 = 64'd110;
    localparam logic [63:0] TAYLOR_DIV_4 = 64'd72;
    localparam logic [63:0] TAYLOR_DIV_3 = 64'd42;
    localparam logic [63:0] TAYLOR_DIV_2 = 64'd20;
    localparam logic [63:0] TAYLOR_DIV_1 = 64'd6;

    // Conduction shape g(u) = 1 - u + sin(2 pi u)/(2 pi) at u = (2k+1)/(2 T), Q28
    function automatic longint fx_shape(input logic [31:0] k);
        logic [63:0] u;
        logic [63:0] t;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] r;
        logic [63:0] s;
        logic [63:0] sc;
        logic        neg;
        longint      res;
        u   = ((64'(k) * 64'd2 + 64'd1) << FX_SHIFT) / FX_U_DEN;
        t   = u;
        neg = 1'b0;
        // fold the angle into the first quadrant
        if (t >= FX_HALF) begin
            t   = t - FX_HALF;
            neg = 1'b1;
        end
        if (t > FX_QUART) begin
            t = FX_HALF - t;
        end
        x  = (t * FX_TWO_PI) >> FX_SHIFT;
        x2 = (x * x) >> FX_SHIFT;
        // Horner form of the Taylor series
        r  = FX_ONE;
        r  = FX_ONE - ((x2 * r) >> FX_SHIFT) / TAYLOR_DIV_7;
        r  = FX_ONE - ((x2 * r) >> FX_SHIFT) / TAYLOR_DIV_6;
        r  = FX_ONE - ((x2 * r) >> FX_SHIFT) / TAYLOR_DIV_5;
        r  = FX_ONE - ((x2 * r) >> FX_SHIFT) / TAYLOR_DIV_4;
        r  = FX_ONE - ((x2 * r) >> FX_SHIFT) / TAYLOR_DIV_3;
        r  = FX_ONE - ((x2 * r) >> FX_SHIFT) / TAYLOR_DIV_2;
        r  = FX_ONE - ((x2 * r) >> FX_SHIFT) / TAYLOR_DIV_1;
        s  = (x * r) >> FX_SHIFT;
        sc = (s << FX_SHIFT) / FX_TWO_PI;
        res = longint'(FX_ONE) - longint'(u);
        if (neg) begin
            res = res - longint'(sc);
        end else begin
            res = res + longint'(sc);
        end
        return res;
    endfunction

    // Raw phase delay for one level, found by bisection over [0, half period]
    function automatic logic [TIME_W-1:0] delay_rom_entry(input int lvl);
        logic [31:0] lo;
        logic [31:0] hi;
        logic [31:0] mid;
        longint      bound;
        lo = 32'd0;
        hi = 32'(HALF_PERIOD_US);
        if (lvl <= 0 || lvl >= LEVEL_STEPS) begin
            return '0;
        end
        bound = longint'(lvl) * longint'(FX_ONE);
        while (lo < hi) begin
            mid = (lo + hi) >> 1;
            if (fx_shape(mid) * longint'(LEVEL_STEPS) <= bound) begin
                hi = mid;
            end else begin
                lo = mid + 32'd1;
            end
        end
        return lo[TIME_W-1:0];
    endfunction

endpackage

[src/tpa_cfg.sv]
// Configuration register bank written through the configuration channel.
module tpa_cfg (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [tpa_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tpa_pkg::CFG_DATA_W-1:0]     cfg_data,
    output tpa_pkg::cfg_t                      cfg
);

    tpa_pkg::cfg_t cfg_reg;
    tpa_pkg::cfg_t cfg_next;

    // Always ready: each write lands in the register bank when it is accepted
    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // Decode the register index and truncate data to the register width
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                tpa_pkg::CFG_OUTPUT_LEVEL:
                    cfg_next.output_level = cfg_data[tpa_pkg::LVL_W-1:0];
                tpa_pkg::CFG_DEBOUNCE:
                    cfg_next.debounce_window = cfg_data[tpa_pkg::TIME_W-1:0];
                tpa_pkg::CFG_PULSE_WIDTH:
                    cfg_next.pulse_width = cfg_data[tpa_pkg::TIME_W-1:0];
                tpa_pkg::CFG_MIN_FIRE_DELAY:
                    cfg_next.min_fire_delay = cfg_data[tpa_pkg::TIME_W-1:0];
                tpa_pkg::CFG_OVERHEAT_LIMIT:
                    cfg_next.overheat_limit = cfg_data[tpa_pkg::TEMP_W-1:0];
                tpa_pkg::CFG_FAN_ON_LIMIT:
                    cfg_next.fan_on_limit = cfg_data[tpa_pkg::TEMP_W-1:0];
                tpa_pkg::CFG_FAN_OFF_LIMIT:
                    cfg_next.fan_off_limit = cfg_data[tpa_pkg::TEMP_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.output_level    <= tpa_pkg::RST_OUTPUT_LEVEL;
            cfg_reg.debounce_window <= tpa_pkg::RST_DEBOUNCE;
            cfg_reg.pulse_width     <= tpa_pkg::RST_PULSE_WIDTH;
            cfg_reg.min_fire_delay  <= tpa_pkg::RST_MIN_FIRE_DELAY;
            cfg_reg.overheat_limit  <= tpa_pkg::RST_OVERHEAT_LIMIT;
            cfg_reg.fan_on_limit    <= tpa_pkg::RST_FAN_ON_LIMIT;
            cfg_reg.fan_off_limit   <= tpa_pkg::RST_FAN_OFF_LIMIT;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

[src/tpa_delay.sv]
// Phase-delay table lookup with level and delay clamping.
module tpa_delay (
    input  tpa_pkg::cfg_t        cfg,
    output tpa_pkg::delay_info_t info
);

    logic [tpa_pkg::LEVEL_STEPS:0][tpa_pkg::TIME_W-1:0] rom_w;
    logic [tpa_pkg::LVL_W-1:0]   lvl;
    logic [tpa_pkg::TIME_W-1:0]  low_clamp;
    logic [tpa_pkg::TIME_W-1:0]  raw;
    logic [tpa_pkg::TIME_W-1:0]  lifted;

    // Table contents are fixed at elaboration
    for (genvar gi = 0; gi <= tpa_pkg::LEVEL_STEPS; gi++) begin : g_rom
        assign rom_w[gi] = tpa_pkg::delay_rom_entry(gi);
    end

    // Limit the level to full scale, then clamp the delay both ways
    always_comb begin
        lvl = (cfg.output_level > tpa_pkg::LEVEL_TOP) ? tpa_pkg::LEVEL_TOP
                                                     : cfg.output_level;
        low_clamp = (cfg.min_fire_delay == '0) ? tpa_pkg::TIME_W'(1)
                                               : cfg.min_fire_delay;
        raw    = rom_w[lvl[tpa_pkg::LEVEL_W-1:0]];
        lifted = (raw < low_clamp) ? low_clamp : raw;
        info.fire_ok = (lvl != '0);
        if (lvl == '0) begin
            info.delay = tpa_pkg::NO_FIRE;
        end else if (lifted > tpa_pkg::DELAY_MAX) begin
            info.delay = tpa_pkg::DELAY_MAX;
        end else begin
            info.delay = lifted;
        end
    end

endmodule

[src/tpa_ctrl.sv]
// Firing timer, debounce, thermal protection and fan state with the result register.
module tpa_ctrl (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              item_valid,
    output logic                              item_take,
    input  logic [tpa_pkg::REQ_W-1:0]         req_type,
    input  logic [tpa_pkg::TEMP_W-1:0]        temp_sample,
    input  logic                              sample_ok,
    input  tpa_pkg::cfg_t                     cfg,
    input  tpa_pkg::delay_info_t              dly,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [tpa_pkg::M_TDATA_W-1:0]     m_tdata
);

    tpa_pkg::phase_t             phase_reg, phase_next;
    logic [tpa_pkg::TIME_W-1:0]  since_reg, since_next;
    logic [tpa_pkg::TIME_W-1:0]  count_reg, count_next;
    logic [tpa_pkg::TIME_W-1:0]  count_dec;
    logic [tpa_pkg::TIME_W-1:0]  pulse_len;
    logic                        enable_reg, enable_next;
    logic                        gate_reg, gate_next;
    logic                        fan_reg, fan_next;
    logic                        heat_reg, heat_next;
    logic                        out_valid_reg, out_valid_next;
    logic [tpa_pkg::M_TDATA_W-1:0] out_data_reg, out_data_next;

    // Take an item whenever the result register is free or being drained
    assign item_take = item_valid && (!out_valid_reg || m_tready);
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    assign count_dec = (count_reg != '0) ? count_reg - tpa_pkg::TIME_W'(1) : '0;
    assign pulse_len = (cfg.pulse_width == '0) ? tpa_pkg::TIME_W'(1) : cfg.pulse_width;

    // Next state for one item
    always_comb begin
        phase_next  = phase_reg;
        since_next  = since_reg;
        count_next  = count_reg;
        enable_next = enable_reg;
        gate_next   = gate_reg;
        fan_next    = fan_reg;
        heat_next   = heat_reg;
        if (item_take) begin
            case (req_type)
                tpa_pkg::REQ_TICK: begin
                    if (since_reg != tpa_pkg::TIME_MAX) begin
                        since_next = since_reg + tpa_pkg::TIME_W'(1);
                    end
                    if (phase_reg != tpa_pkg::PH_IDLE) begin
                        count_next = count_dec;
                        if (count_dec == '0) begin
                            unique case (phase_reg)
                                tpa_pkg::PH_DELAY: begin
                                    gate_next  = 1'b1;
                                    phase_next = tpa_pkg::PH_PULSE;
                                    count_next = pulse_len;
                                end
                                default: begin
                                    gate_next  = 1'b0;
                                    phase_next = tpa_pkg::PH_IDLE;
                                end
                            endcase
                        end
                    end
                end
                tpa_pkg::REQ_EDGE: begin
                    if (since_reg >= cfg.debounce_window) begin
                        since_next = '0;
                        if (enable_reg && dly.fire_ok) begin
                            phase_next = tpa_pkg::PH_DELAY;
                            count_next = dly.delay;
                        end
                    end
                end
                tpa_pkg::REQ_SAMPLE: begin
                    if (!sample_ok) begin
                        // sensor failure: force the fan, latch and shut off
                        fan_next = 1'b1;
                        if (!heat_reg) begin
                            heat_next   = 1'b1;
                            enable_next = 1'b0;
                            phase_next  = tpa_pkg::PH_IDLE;
                            count_next  = '0;
                            gate_next   = 1'b0;
                        end
                    end else begin
                        if (temp_sample >= cfg.overheat_limit) begin
                            if (!heat_reg) begin
                                heat_next   = 1'b1;
                                enable_next = 1'b0;
                                phase_next  = tpa_pkg::PH_IDLE;
                                count_next  = '0;
                                gate_next   = 1'b0;
                                fan_next    = 1'b1;
                            end
                        end else begin
                            heat_next = 1'b0;
                            // fan hysteresis only while the latch is clear
                            if (!fan_reg && temp_sample >= cfg.fan_on_limit) begin
                                fan_next = 1'b1;
                            end else if (fan_reg && temp_sample < cfg.fan_off_limit) begin
                                fan_next = 1'b0;
                            end
                        end
                    end
                end
                tpa_pkg::REQ_ENABLE: begin
                    enable_next = 1'b1;
                    since_next  = '0;
                end
                tpa_pkg::REQ_DISABLE: begin
                    enable_next = 1'b0;
                    phase_next  = tpa_pkg::PH_IDLE;
                    count_next  = '0;
                    gate_next   = 1'b0;
                end
                default: ;
            endcase
        end
    end

    // Result register: load on take, drop once transferred
    always_comb begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (item_take) begin
            out_valid_next = 1'b1;
            out_data_next  = {2'b00, phase_next, dly.delay,
                              enable_next, heat_next, fan_next, gate_next};
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= tpa_pkg::PH_IDLE;
            since_reg     <= '0;
            count_reg     <= '0;
            enable_reg    <= 1'b0;
            gate_reg      <= 1'b0;
            fan_reg       <= 1'b0;
            heat_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            phase_reg     <= phase_next;
            since_reg     <= since_next;
            count_reg     <= count_next;
            enable_reg    <= enable_next;
            gate_reg      <= gate_next;
            fan_reg       <= fan_next;
            heat_reg      <= heat_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
    end

endmodule

[src/triac_phase_angle_controller_core.sv]
// Top level of the triac phase-angle controller: input register, configuration, lookup, control.
//
//  Channel  Dir  Handshake              Contents
//  s_       in   s_tvalid / s_tready    tuser: req_type, sample_ok; tdata: temp_sample
//  m_       out  m_tvalid / m_tready    tdata: gate, fan, overheat, enabled, delay, phase
//  cfg_     in   cfg_valid / cfg_ready  cfg_index, cfg_data (always ready)
//
// One item per cycle sustained while m_tready stays high; an input transfer loads the input
// register, and the result register, which drives m_tvalid, is loaded when ctrl takes the item.
// Reset is synchronous on aresetn low; the delay table is constant and needs no fill.
// A stalled m_ side holds the result register; the input register still takes one
// more item, and s_tready falls only when both registers are occupied.
module triac_phase_angle_controller_core (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [tpa_pkg::S_TDATA_W-1:0]      s_tdata,  // [11:0] temp_sample
    input  logic [tpa_pkg::S_TUSER_W-1:0]      s_tuser,  // [2:0] req_type, [3] sample_ok
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [0] gate_drive, [1] fan_drive, [2] overheat_flag, [3] enabled_flag,
    // [19:4] active_delay, [21:20] timer_phase
    output logic [tpa_pkg::M_TDATA_W-1:0]      m_tdata,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [tpa_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tpa_pkg::CFG_DATA_W-1:0]     cfg_data
);

    logic                          in_valid_reg, in_valid_next;
    logic [tpa_pkg::REQ_W-1:0]     req_reg;
    logic [tpa_pkg::TEMP_W-1:0]    temp_reg;
    logic                          ok_reg;
    logic                          item_take;
    logic                          s_xfer;
    tpa_pkg::cfg_t                 cfg;
    tpa_pkg::delay_info_t          dly;

    // Input register is free when empty or when its item moves on this cycle
    assign s_tready = !in_valid_reg || item_take;
    assign s_xfer   = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_xfer) begin
            in_valid_next = 1'b1;
        end else if (item_take) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    // Hold the payload until the next transfer
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            req_reg  <= s_tuser[tpa_pkg::REQ_W-1:0];
            ok_reg   <= s_tuser[tpa_pkg::REQ_W];
            temp_reg <= s_tdata[tpa_pkg::TEMP_W-1:0];
        end
    end

    tpa_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tpa_delay u_delay (
        .cfg  (cfg),
        .info (dly)
    );

    tpa_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .item_valid  (in_valid_reg),
        .item_take   (item_take),
        .req_type    (req_reg),
        .temp_sample (temp_reg),
        .sample_ok   (ok_reg),
        .cfg         (cfg),
        .dly         (dly),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

endmodule

[sim/tb_triac_phase_angle_controller_core.sv]
// Self-checking testbench for the triac phase-angle controller core.
module tb_triac_phase_angle_controller_core;
    timeunit 1ns;
    timeprecision 1ps;

    // Request codes outside the defined set; the block must report state unchanged
    localparam logic [tpa_pkg::REQ_W-1:0] REQ_SPARE_A = 3'd5;
    localparam logic [tpa_pkg::REQ_W-1:0] REQ_SPARE_B = 3'd6;
    localparam logic [tpa_pkg::REQ_W-1:0] REQ_SPARE_C = 3'd7;

    // Q28 arithmetic for the delay table
    localparam int          Q_BITS     = 28;
    localparam logic [63:0] Q_UNIT     = 64'd1 << Q_BITS;
    localparam logic [63:0] Q_TWO_PI   = 64'd1686629713;
    localparam int          SERIES_LEN = 7;

    localparam int N_PHASES        = 18;
    localparam int ITEMS_PER_PHASE = 80;
    localparam int HOLD_CYCLES     = 120;

    typedef struct {
        logic [tpa_pkg::REQ_W-1:0]  kind;
        logic [tpa_pkg::TEMP_W-1:0] reading;
        logic                       ok;
    } dimmer_req_t;

    typedef struct packed {
        logic                       gate;
        logic                       fan;
        logic                       hot;
        logic                       en;
        logic [tpa_pkg::TIME_W-1:0] delay;
        tpa_pkg::phase_t            phase;
    } dimmer_result_t;

    // DUT connections
    logic                           aclk;
    logic                           aresetn   = 1'b0;
    logic                           s_tvalid  = 1'b0;
    logic                           s_tready;
    logic [tpa_pkg::S_TDATA_W-1:0]  s_tdata   = '0;
    logic [tpa_pkg::S_TUSER_W-1:0]  s_tuser   = '0;
    logic                           m_tvalid;
    logic                           m_tready  = 1'b0;
    logic [tpa_pkg::M_TDATA_W-1:0]  m_tdata;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [tpa_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [tpa_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    triac_phase_angle_controller_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Stimulus and scoreboard storage
    dimmer_req_t    pending_reqs[$];
    dimmer_result_t expected_outputs[$];
    dimmer_req_t    next_req;
    dimmer_result_t oldest_expect;
    logic           in_taken = 1'b0;
    int             error_count  = 0;
    int             queued_total = 0;
    int             send_idle_pct = 0;
    int             recv_idle_pct = 0;
    int             holds_asked  = 0;
    int             holds_served = 0;
    int             hold_left    = 0;

    // Predictor: configuration copy
    logic [tpa_pkg::LVL_W-1:0]  lvl_reg;
    logic [tpa_pkg::TIME_W-1:0] debounce_reg;
    logic [tpa_pkg::TIME_W-1:0] pulse_reg;
    logic [tpa_pkg::TIME_W-1:0] min_delay_reg;
    logic [tpa_pkg::TEMP_W-1:0] hot_limit_reg;
    logic [tpa_pkg::TEMP_W-1:0] fan_on_reg;
    logic [tpa_pkg::TEMP_W-1:0] fan_off_reg;

    // Predictor: controller state
    logic [tpa_pkg::TIME_W-1:0] us_since_zc;
    logic                       firing_on;
    tpa_pkg::phase_t            timer_ph;
    logic [tpa_pkg::TIME_W-1:0] ticks_left;
    logic                       gate_q;
    logic                       fan_q;
    logic                       hot_q;
    logic [tpa_pkg::TIME_W-1:0] delay_table [0:tpa_pkg::LEVEL_STEPS];

    // Remaining conduction 1 - u + sin(2 pi u)/(2 pi) at u = (2k+1)/(2T), Q28
    function automatic longint conduction_q28(input int unsigned k);
        logic [63:0] u;
        logic [63:0] ang;
        logic [63:0] x;
        logic [63:0] xsq;
        logic [63:0] acc;
        logic [63:0] sn;
        logic [63:0] scaled;
        logic        neg;
        int          n;
        u   = ((64'(k) * 64'd2 + 64'd1) << Q_BITS) / 64'(2 * tpa_pkg::HALF_PERIOD_US);
        ang = u;
        neg = 1'b0;
        // fold into the first quarter turn
        if (ang >= Q_UNIT / 2) begin
            ang = ang - Q_UNIT / 2;
            neg = 1'b1;
        end
        if (ang > Q_UNIT / 4) begin
            ang = Q_UNIT / 2 - ang;
        end
        x   = (ang * Q_TWO_PI) >> Q_BITS;
        xsq = (x * x) >> Q_BITS;
        acc = Q_UNIT;
        for (n = SERIES_LEN; n >= 1; n--) begin
            acc = Q_UNIT - ((xsq * acc) >> Q_BITS) / 64'((2 * n) * (2 * n + 1));
        end
        sn     = (x * acc) >> Q_BITS;
        scaled = (sn << Q_BITS) / Q_TWO_PI;
        if (neg) begin
            return longint'(Q_UNIT) - longint'(u) - longint'(scaled);
        end
        return longint'(Q_UNIT) - longint'(u) + longint'(scaled);
    endfunction

    // Smallest delay whose remaining conduction falls to the level, by bisection
    function automatic logic [tpa_pkg::TIME_W-1:0] phase_delay_for(input int lvl);
        int unsigned span_lo;
        int unsigned span_hi;
        int unsigned mid;
        longint      bound;
        span_lo = 0;
        span_hi = tpa_pkg::HALF_PERIOD_US;
        bound   = longint'(lvl) << Q_BITS;
        while (span_lo < span_hi) begin
            mid = (span_lo + span_hi) / 2;
            if (conduction_q28(mid) * longint'(tpa_pkg::LEVEL_STEPS) <= bound) begin
                span_hi = mid;
            end else begin
                span_lo = mid + 1;
            end
        end
        return tpa_pkg::TIME_W'(span_lo);
    endfunction

    // Clamped delay of the current level, or the no-fire marker at level zero
    function automatic logic [tpa_pkg::TIME_W-1:0] firing_delay();
        int          lvl;
        logic [15:0] floor_v;
        logic [15:0] d;
        lvl = (int'(lvl_reg) > tpa_pkg::LEVEL_STEPS) ? tpa_pkg::LEVEL_STEPS : int'(lvl_reg);
        if (lvl == 0) begin
            return tpa_pkg::NO_FIRE;
        end
        floor_v = (min_delay_reg == '0) ? 16'd1 : min_delay_reg;
        d = delay_table[lvl];
        if (d < floor_v) d = floor_v;
        if (d > tpa_pkg::DELAY_MAX) d = tpa_pkg::DELAY_MAX;
        return d;
    endfunction

    function automatic void cut_output();
        firing_on  = 1'b0;
        timer_ph   = tpa_pkg::PH_IDLE;
        ticks_left = '0;
        gate_q     = 1'b0;
    endfunction

    function automatic void reset_predictor();
        lvl_reg       = tpa_pkg::RST_OUTPUT_LEVEL;
        debounce_reg  = tpa_pkg::RST_DEBOUNCE;
        pulse_reg     = tpa_pkg::RST_PULSE_WIDTH;
        min_delay_reg = tpa_pkg::RST_MIN_FIRE_DELAY;
        hot_limit_reg = tpa_pkg::RST_OVERHEAT_LIMIT;
        fan_on_reg    = tpa_pkg::RST_FAN_ON_LIMIT;
        fan_off_reg   = tpa_pkg::RST_FAN_OFF_LIMIT;
        us_since_zc   = '0;
        firing_on     = 1'b0;
        timer_ph      = tpa_pkg::PH_IDLE;
        ticks_left    = '0;
        gate_q        = 1'b0;
        fan_q         = 1'b0;
        hot_q         = 1'b0;
    endfunction

    function automatic void latch_register(input logic [tpa_pkg::CFG_IDX_W-1:0] idx,
                                           input logic [tpa_pkg::CFG_DATA_W-1:0] value);
        case (idx)
            tpa_pkg::CFG_OUTPUT_LEVEL:   lvl_reg       = value[tpa_pkg::LVL_W-1:0];
            tpa_pkg::CFG_DEBOUNCE:       debounce_reg  = value;
            tpa_pkg::CFG_PULSE_WIDTH:    pulse_reg     = value;
            tpa_pkg::CFG_MIN_FIRE_DELAY: min_delay_reg = value;
            tpa_pkg::CFG_OVERHEAT_LIMIT: hot_limit_reg = value[tpa_pkg::TEMP_W-1:0];
            tpa_pkg::CFG_FAN_ON_LIMIT:   fan_on_reg    = value[tpa_pkg::TEMP_W-1:0];
            tpa_pkg::CFG_FAN_OFF_LIMIT:  fan_off_reg   = value[tpa_pkg::TEMP_W-1:0];
            default: ;
        endcase
    endfunction

    // Apply one request to the predicted state and return the outputs after it
    function automatic dimmer_result_t advance_dimmer(
        input logic [tpa_pkg::REQ_W-1:0]  kind,
        input logic [tpa_pkg::TEMP_W-1:0] reading,
        input logic                       ok
    );
        dimmer_result_t r;
        case (kind)
            tpa_pkg::REQ_TICK: begin
                if (us_since_zc != tpa_pkg::TIME_MAX) us_since_zc = us_since_zc + 16'd1;
                if (timer_ph != tpa_pkg::PH_IDLE) begin
                    if (ticks_left != '0) ticks_left = ticks_left - 16'd1;
                    if (ticks_left == '0) begin
                        if (timer_ph == tpa_pkg::PH_DELAY) begin
                            gate_q     = 1'b1;
                            timer_ph   = tpa_pkg::PH_PULSE;
                            ticks_left = (pulse_reg == '0) ? 16'd1 : pulse_reg;
                        end else begin
                            gate_q   = 1'b0;
                            timer_ph = tpa_pkg::PH_IDLE;
                        end
                    end
                end
            end
            tpa_pkg::REQ_EDGE: begin
                if (us_since_zc >= debounce_reg) begin
                    us_since_zc = '0;
                    if (firing_on && lvl_reg != '0) begin
                        timer_ph   = tpa_pkg::PH_DELAY;
                        ticks_left = firing_delay();
                    end
                end
            end
            tpa_pkg::REQ_SAMPLE: begin
                if (!ok) begin
                    fan_q = 1'b1;
                    if (!hot_q) begin
                        hot_q = 1'b1;
                        cut_output();
                    end
                end else begin
                    if (reading >= hot_limit_reg) begin
                        if (!hot_q) begin
                            hot_q = 1'b1;
                            cut_output();
                            fan_q = 1'b1;
                        end
                    end else begin
                        hot_q = 1'b0;
                    end
                    // fan hysteresis only while the latch is clear
                    if (!hot_q) begin
                        if (!fan_q && reading >= fan_on_reg) fan_q = 1'b1;
                        else if (fan_q && reading < fan_off_reg) fan_q = 1'b0;
                    end
                end
            end
            tpa_pkg::REQ_ENABLE: begin
                firing_on   = 1'b1;
                us_since_zc = '0;
            end
            tpa_pkg::REQ_DISABLE: cut_output();
            default: ;
        endcase
        r.gate  = gate_q;
        r.fan   = fan_q;
        r.hot   = hot_q;
        r.en    = firing_on;
        r.delay = firing_delay();
        r.phase = timer_ph;
        return r;
    endfunction

    task automatic flag_error(input string what);
        $display("%0t ERROR %s", $time, what);
        error_count++;
    endtask

    function automatic void queue_req(input logic [tpa_pkg::REQ_W-1:0]  kind,
                                      input logic [tpa_pkg::TEMP_W-1:0] reading,
                                      input logic                       ok);
        dimmer_req_t q;
        q.kind    = kind;
        q.reading = reading;
        q.ok      = ok;
        pending_reqs.push_back(q);
        queued_total++;
    endfunction

    // Clock
    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Input driver: advance on transfer, idle at random
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || in_taken) begin
            if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                next_req = pending_reqs.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= tpa_pkg::S_TDATA_W'(next_req.reading);
                s_tuser  <= {next_req.ok, next_req.kind};
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Result receiver: random stalls, plus long hold-offs on request
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (holds_served != holds_asked) begin
            m_tready     <= 1'b0;
            holds_served <= holds_served + 1;
            hold_left    <= HOLD_CYCLES;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Monitor: predict on input transfer, check on result transfer
    always @(posedge aclk) begin
        in_taken <= s_tvalid && s_tready;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) latch_register(cfg_index, cfg_data);
            if (s_tvalid && s_tready) begin
                expected_outputs.push_back(advance_dimmer(s_tuser[tpa_pkg::REQ_W-1:0],
                                                          s_tdata[tpa_pkg::TEMP_W-1:0],
                                                          s_tuser[tpa_pkg::REQ_W]));
            end
            if (m_tvalid && m_tready) begin
                if (expected_outputs.size() == 0) begin
                    flag_error($sformatf("result %h with nothing expected", m_tdata));
                end else begin
                    oldest_expect = expected_outputs.pop_front();
                    if (m_tdata[0] !== oldest_expect.gate)
                        flag_error($sformatf("gate_drive got %b want %b",
                                             m_tdata[0], oldest_expect.gate));
                    if (m_tdata[1] !== oldest_expect.fan)
                        flag_error($sformatf("fan_drive got %b want %b",
                                             m_tdata[1], oldest_expect.fan));
                    if (m_tdata[2] !== oldest_expect.hot)
                        flag_error($sformatf("overheat_flag got %b want %b",
                                             m_tdata[2], oldest_expect.hot));
                    if (m_tdata[3] !== oldest_expect.en)
                        flag_error($sformatf("enabled_flag got %b want %b",
                                             m_tdata[3], oldest_expect.en));
                    if (m_tdata[19:4] !== oldest_expect.delay)
                        flag_error($sformatf("active_delay got %0d want %0d",
                                             m_tdata[19:4], oldest_expect.delay));
                    if (m_tdata[21:20] !== oldest_expect.phase)
                        flag_error($sformatf("timer_phase got %0d want %0d",
                                             m_tdata[21:20], oldest_expect.phase));
                end
            end
        end
    end

    // Wait until every item has gone in and every result has come out
    task automatic wait_idle();
        while (pending_reqs.size() != 0 || s_tvalid || expected_outputs.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_register(input tpa_pkg::cfg_idx_t idx,
                                  input logic [tpa_pkg::CFG_DATA_W-1:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic write_all_registers(input logic [15:0] lvl, input logic [15:0] db,
                                       input logic [15:0] pw, input logic [15:0] md,
                                       input logic [15:0] hl, input logic [15:0] fon,
                                       input logic [15:0] foff);
        write_register(tpa_pkg::CFG_OUTPUT_LEVEL, lvl);
        write_register(tpa_pkg::CFG_DEBOUNCE, db);
        write_register(tpa_pkg::CFG_PULSE_WIDTH, pw);
        write_register(tpa_pkg::CFG_MIN_FIRE_DELAY, md);
        write_register(tpa_pkg::CFG_OVERHEAT_LIMIT, hl);
        write_register(tpa_pkg::CFG_FAN_ON_LIMIT, fon);
        write_register(tpa_pkg::CFG_FAN_OFF_LIMIT, foff);
    endtask

    // Run ends here if the block stops responding
    initial begin
        #2000000;
        $display("Test completed with failures");
        $finish;
    end

    // Stimulus sequence
    initial begin
        int          p;
        int          j;
        int          lvl;
        int          ticks;
        int          chunk_max;
        int          start_count;
        logic [15:0] c_lvl;
        logic [15:0] c_db;
        logic [15:0] c_pw;
        logic [15:0] c_md;
        logic [15:0] c_hot;
        logic [15:0] c_fon;
        logic [15:0] c_foff;

        // build the expected delay table before any traffic
        delay_table[0]                    = '0;
        delay_table[tpa_pkg::LEVEL_STEPS] = '0;
        for (lvl = 1; lvl < tpa_pkg::LEVEL_STEPS; lvl++) begin
            delay_table[lvl] = phase_delay_for(lvl);
        end
        reset_predictor();

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        send_idle_pct = 22;
        recv_idle_pct = 49;

        // Directed: spare codes, fan hysteresis, overheat latch, sensor failure
        queue_req(REQ_SPARE_A, 12'h000, 1'b0);
        queue_req(REQ_SPARE_B, 12'hFFF, 1'b1);
        queue_req(REQ_SPARE_C, 12'h800, 1'b1);
        queue_req(tpa_pkg::REQ_SAMPLE, 12'd2600, 1'b1);
        queue_req(tpa_pkg::REQ_SAMPLE, 12'd2300, 1'b1);
        queue_req(tpa_pkg::REQ_SAMPLE, 12'd2199, 1'b1);
        queue_req(tpa_pkg::REQ_SAMPLE, 12'hFFF, 1'b1);
        queue_req(tpa_pkg::REQ_ENABLE, 12'h000, 1'b1);
        queue_req(tpa_pkg::REQ_SAMPLE, 12'h000, 1'b1);
        queue_req(tpa_pkg::REQ_SAMPLE, 12'h000, 1'b0);
        queue_req(tpa_pkg::REQ_ENABLE, 12'h000, 1'b1);
        queue_req(tpa_pkg::REQ_TICK, 12'h000, 1'b1);
        queue_req(tpa_pkg::REQ_EDGE, 12'h000, 1'b1);
        queue_req(tpa_pkg::REQ_DISABLE, 12'h000, 1'b1);
        wait_idle();

        // Directed: full level, zero pulse and zero minimum delay, edge during the pulse
        write_all_registers(16'd100, 16'd0, 16'd0, 16'd0, 16'd4095, 16'd4095, 16'd0);
        queue_req(tpa_pkg::REQ_ENABLE, 12'h000, 1'b1);
        queue_req(tpa_pkg::REQ_EDGE, 12'h000, 1'b1);
        queue_req(tpa_pkg::REQ_TICK, 12'h000, 1'b1);
        queue_req(tpa_pkg::REQ_TICK, 12'h000, 1'b1);
        queue_req(tpa_pkg::REQ_EDGE, 12'h000, 1'b1);
        queue_req(tpa_pkg::REQ_TICK, 12'h000, 1'b1);
        queue_req(tpa_pkg::REQ_EDGE, 12'h000, 1'b1);
        queue_req(tpa_pkg::REQ_TICK, 12'h000, 1'b1);
        queue_req(tpa_pkg::REQ_TICK, 12'h000, 1'b1);
        queue_req(tpa_pkg::REQ_SAMPLE, 12'hFFF, 1'b1);
        wait_idle();

        // Random phases, each with its own register setting
        for (p = 0; p < N_PHASES; p++) begin
            if (p < 6) begin
                send_idle_pct = 22;
                recv_idle_pct = 49;
            end else if (p < 12) begin
                send_idle_pct = 49;
                recv_idle_pct = 22;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            case (p)
                0: begin
                    c_lvl = 16'd127; c_db = 16'd0; c_pw = 16'hFFFF; c_md = 16'd0;
                    c_hot = 16'd4095; c_fon = 16'd4095; c_foff = 16'd0;
                end
                1: begin
                    c_lvl = 16'd0; c_db = 16'hFFFF; c_pw = 16'd1; c_md = 16'hFFFF;
                    c_hot = 16'd0; c_fon = 16'd0; c_foff = 16'd4095;
                end
                2: begin
                    c_lvl = 16'd99; c_db = 16'd0; c_pw = 16'd5; c_md = 16'd1;
                    c_hot = 16'd3000; c_fon = 16'd2500; c_foff = 16'd2200;
                end
                3: begin
                    c_lvl = 16'd100; c_db = 16'd2; c_pw = 16'd3; c_md = 16'hFFFF;
                    c_hot = 16'd3500; c_fon = 16'd2000; c_foff = 16'd1000;
                end
                default: begin
                    c_lvl = ($urandom_range(0, 9) < 6) ? 16'($urandom_range(100, 127))
                                                        : 16'($urandom_range(1, 99));
                    c_db  = 16'($urandom_range(0, 12));
                    c_pw  = 16'($urandom_range(0, 16));
                    c_md  = 16'($urandom_range(0, 24));
                    c_hot = 16'($urandom_range(1500, 4095));
                    c_fon = 16'($urandom_range(0, c_hot));
                    c_foff = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(0, 4095))
                                                         : 16'($urandom_range(0, c_fon));
                end
            endcase
            write_all_registers(c_lvl, c_db, c_pw, c_md, c_hot, c_fon, c_foff);

            chunk_max = ((c_md == 0) ? 1 : int'(c_md)) + ((c_pw == 0) ? 1 : int'(c_pw)) + 8;
            if (chunk_max > 60) chunk_max = 60;

            // mostly enable / edge / tick runs, with samples and noise mixed in
            start_count = queued_total;
            queue_req(tpa_pkg::REQ_ENABLE, 12'h000, 1'b1);
            while (queued_total - start_count < ITEMS_PER_PHASE) begin
                if ($urandom_range(0, 3) != 0) begin
                    if ($urandom_range(0, 3) == 0) begin
                        queue_req(tpa_pkg::REQ_ENABLE, tpa_pkg::TEMP_W'($urandom), 1'b1);
                    end
                    queue_req(tpa_pkg::REQ_EDGE, tpa_pkg::TEMP_W'($urandom), 1'($urandom));
                    ticks = $urandom_range(0, chunk_max);
                    for (j = 0; j < ticks; j++) begin
                        if ($urandom_range(0, 15) == 0) begin
                            queue_req(tpa_pkg::REQ_SAMPLE,
                                      ($urandom_range(0, 3) == 0 || c_hot == 0)
                                          ? tpa_pkg::TEMP_W'($urandom_range(0, 4095))
                                          : tpa_pkg::TEMP_W'($urandom_range(0, c_hot - 1)),
                                      $urandom_range(0, 11) != 0);
                        end else begin
                            queue_req(tpa_pkg::REQ_TICK, tpa_pkg::TEMP_W'($urandom),
                                      1'($urandom));
                        end
                    end
                end else begin
                    queue_req(tpa_pkg::REQ_W'($urandom_range(0, 7)),
                              tpa_pkg::TEMP_W'($urandom_range(0, 4095)),
                              $urandom_range(0, 9) != 0);
                end
            end

            // hold the result side off so the input stalls
            if (p == 2 || p == 15) holds_asked++;
            wait_idle();
        end

        // Sweep every level value, including those above range, against the table
        write_register(tpa_pkg::CFG_MIN_FIRE_DELAY, 16'd1);
        for (lvl = 0; lvl < 128; lvl++) begin
            write_register(tpa_pkg::CFG_OUTPUT_LEVEL, 16'(lvl));
            queue_req(tpa_pkg::REQ_TICK, 12'h000, 1'b1);
            wait_idle();
        end

        repeat (8) @(posedge aclk);
        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
